[rtl/ptd_pkg.sv]
// Package for the periodic task dispatcher.
// Holds the operation and status codes and the table row layout.
// No dependencies.
`default_nettype none

package ptd_pkg;

    // Operation codes carried on i_op
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Status codes reported on o_status
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Most fired tasks reported for one tick
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // One row of the task table
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] period;
        logic [15:0] countdown;
        logic [7:0]  priority_val;
    } t_entry;

endpackage

`default_nettype wire

[rtl/ptd_table.sv]
// Task table storage: one write port and one registered read port.
// Depends on ptd_pkg for the row layout.
`default_nettype none

module ptd_table
    import ptd_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one row, data registered for the next cycle
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/periodic_task_dispatcher_unit.sv]
// Periodic task dispatcher: sequencer walking an ordered task table.
// Depends on ptd_pkg and ptd_table.
`default_nettype none

// Usage
//   A transaction is taken at a rising edge with start high and busy low:
//   i_op selects tick, add or remove; i_task_id, i_period and
//   i_priority_req carry the operands. busy stays high until the last
//   result has been produced.
//   Results appear on o_fired_valid, o_fired_task, o_status and o_last for
//   one cycle each, marked by o_strobe. A tick gives one result per fired
//   task in table order (at most eight), or a single empty result; add and
//   remove give one status result. o_last marks the final one.
//   Walk: a tick or remove reads every row of the table in order, an add
//   walks backward from the last row until it places the new one (a shift
//   ending at the front row passes through the insert state too). The
//   table read port gives one row per cycle; busy drops as the final
//   result is shown, so the next start can follow at once.
//   Reset clears the task count and the sequencer; table rows are not
//   cleared and are only read below the count. The receiver cannot stall:
//   every strobe is a transaction.
module periodic_task_dispatcher_unit
    import ptd_pkg::*;
#(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [15:0] i_period,
    input  wire logic [7:0]  i_priority_req,
    output logic             o_strobe,
    output logic             o_fired_valid,
    output logic [7:0]       o_fired_task,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_last_idx, n_last_idx;
    logic [CW-1:0]         r_wr, n_wr;
    logic                  r_found, n_found;
    logic                  r_pend_vld, n_pend_vld;
    logic [7:0]            r_pend_id, n_pend_id;
    logic [RES_CNT_W-1:0]  r_nrep, n_nrep;
    logic [1:0]            r_op, n_op;
    logic [7:0]            r_id, n_id;
    logic [15:0]           r_per, n_per;
    logic [7:0]            r_pri, n_pri;
    logic [1:0]            r_status, n_status;
    logic                  r_strobe, n_strobe;
    logic                  r_fired_valid, n_fired_valid;
    logic [7:0]            r_fired_task, n_fired_task;
    logic [1:0]            r_out_status, n_out_status;
    logic                  r_last, n_last;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    t_entry                wr_data;
    logic [IW-1:0]         rd_addr;
    t_entry                rd_data;
    t_entry                new_entry;
    logic                  accept;

    ptd_table #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // New row built from the latched add operands
    always_comb begin
        new_entry.id           = r_id;
        new_entry.period       = r_per;
        new_entry.countdown    = r_per;
        new_entry.priority_val = r_pri;
    end

    // Sequencer next state and table port control
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_cur         = r_cur;
        n_last_idx    = r_last_idx;
        n_wr          = r_wr;
        n_found       = r_found;
        n_pend_vld    = r_pend_vld;
        n_pend_id     = r_pend_id;
        n_nrep        = r_nrep;
        n_op          = r_op;
        n_id          = r_id;
        n_per         = r_per;
        n_pri         = r_pri;
        n_status      = r_status;
        n_strobe      = 1'b0;
        n_fired_valid = 1'b0;
        n_fired_task  = '0;
        n_out_status  = ST_DONE;
        n_last        = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_cur + IW'(1);
        wr_data       = rd_data;
        rd_addr       = r_cur + IW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op       = i_op;
                    n_id       = i_task_id;
                    n_per      = i_period;
                    n_pri      = i_priority_req;
                    n_status   = ST_DONE;
                    n_found    = 1'b0;
                    n_wr       = '0;
                    n_pend_vld = 1'b0;
                    n_nrep     = '0;
                    n_cur      = '0;
                    n_last_idx = IW'(r_count - CW'(1));
                    rd_addr    = '0;
                    priority case (i_op)
                        OP_TICK, OP_REMOVE: begin
                            n_state = (r_count == '0) ? S_FINISH : S_WALK;
                        end
                        OP_ADD: begin
                            if (r_count == CW'(MAX_TASKS)) begin
                                n_status = ST_FULL;
                                n_state  = S_FINISH;
                            end else if (r_count == '0) begin
                                // Empty table: place the row at the front
                                wr_en                = 1'b1;
                                wr_addr              = '0;
                                wr_data.id           = i_task_id;
                                wr_data.period       = i_period;
                                wr_data.countdown    = i_period;
                                wr_data.priority_val = i_priority_req;
                                n_count              = CW'(1);
                                n_state              = S_FINISH;
                            end else begin
                                // Walk backward from the last row
                                rd_addr = IW'(r_count - CW'(1));
                                n_cur   = IW'(r_count - CW'(1));
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_WALK: begin
                priority case (r_op)
                    OP_TICK: begin
                        // Reload or count down, report firings one behind
                        wr_en   = 1'b1;
                        wr_addr = r_cur;
                        if (rd_data.countdown == '0) begin
                            wr_data.countdown = rd_data.period;
                            if (r_nrep < RES_CNT_W'(MAX_RESULTS)) begin
                                if (r_pend_vld) begin
                                    n_strobe      = 1'b1;
                                    n_fired_valid = 1'b1;
                                    n_fired_task  = r_pend_id;
                                end
                                n_pend_vld = 1'b1;
                                n_pend_id  = rd_data.id;
                                n_nrep     = r_nrep + RES_CNT_W'(1);
                            end
                        end else begin
                            wr_data.countdown = rd_data.countdown - 16'd1;
                        end
                        if (r_cur == r_last_idx) begin
                            n_state = S_FINISH;
                        end else begin
                            n_cur = r_cur + IW'(1);
                        end
                    end
                    OP_ADD: begin
                        rd_addr = r_cur - IW'(1);
                        wr_en   = 1'b1;
                        if (rd_data.priority_val > r_pri) begin
                            // Shift this row up one place
                            if (r_cur == '0) begin
                                n_state = S_INSERT;
                            end else begin
                                n_cur = r_cur - IW'(1);
                            end
                        end else begin
                            wr_data = new_entry;
                            n_count = r_count + CW'(1);
                            n_state = S_FINISH;
                        end
                    end
                    OP_REMOVE: begin
                        // Drop matching rows, compact the rest
                        if (rd_data.id == r_id) begin
                            n_found = 1'b1;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_wr[IW-1:0];
                            n_wr    = r_wr + CW'(1);
                        end
                        if (r_cur == r_last_idx) begin
                            n_count = n_wr;
                            n_state = S_FINISH;
                        end else begin
                            n_cur = r_cur + IW'(1);
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end

            S_INSERT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = new_entry;
                n_count = r_count + CW'(1);
                n_state = S_FINISH;
            end

            S_FINISH: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                priority case (r_op)
                    OP_TICK: begin
                        n_fired_valid = r_pend_vld;
                        n_fired_task  = r_pend_vld ? r_pend_id : 8'd0;
                    end
                    OP_ADD: begin
                        n_out_status = r_status;
                    end
                    OP_REMOVE: begin
                        n_out_status = r_found ? ST_DONE : ST_NOT_FOUND;
                    end
                    default: begin
                        n_out_status = ST_DONE;
                    end
                endcase
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_strobe   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_strobe   <= n_strobe;
            r_pend_vld <= n_pend_vld;
        end
        r_cur         <= n_cur;
        r_last_idx    <= n_last_idx;
        r_wr          <= n_wr;
        r_found       <= n_found;
        r_pend_id     <= n_pend_id;
        r_nrep        <= n_nrep;
        r_op          <= n_op;
        r_id          <= n_id;
        r_per         <= n_per;
        r_pri         <= n_pri;
        r_status      <= n_status;
        r_fired_valid <= n_fired_valid;
        r_fired_task  <= n_fired_task;
        r_out_status  <= n_out_status;
        r_last        <= n_last;
    end

    assign o_strobe      = r_strobe;
    assign o_fired_valid = r_fired_valid;
    assign o_fired_task  = r_fired_task;
    assign o_status      = r_out_status;
    assign o_last        = r_last;

    // The task count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count above table depth");

    // An accepted transaction keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // The final result coincides with the block going idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("final result while still busy");

    // A result that is not final is a firing, with more still to come
    a_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (busy && o_fired_valid))
        else $error("intermediate result out of place");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for periodic_task_dispatcher_unit.
// Drives tick, add, remove and unused-opcode transactions, predicts every result in a
// local copy of the ordered task table and checks each strobe against it.
`timescale 1ns / 1ps

module tb;
    import ptd_pkg::*;

    localparam int          TABLE_DEPTH    = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 16;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    // One expected result of a transaction
    typedef struct {
        logic       fired_valid;
        logic [7:0] fired_task;
        t_status    status;
        logic       last;
    } dispatch_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [7:0]  i_task_id;
    logic [15:0] i_period;
    logic [7:0]  i_priority_req;
    logic        o_strobe;
    logic        o_fired_valid;
    logic [7:0]  o_fired_task;
    logic [1:0]  o_status;
    logic        o_last;

    // Local copy of the task table, kept in dispatch order
    logic [7:0]  sched_id        [TABLE_DEPTH];
    logic [15:0] sched_period    [TABLE_DEPTH];
    logic [15:0] sched_countdown [TABLE_DEPTH];
    logic [7:0]  sched_priority  [TABLE_DEPTH];
    int          sched_count;

    dispatch_result_t pending_results_q[$];
    int               err_count;
    int               sender_idle_pct;
    int               quiet_cycles;

    periodic_task_dispatcher_unit #(
        .MAX_TASKS(TABLE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_task_id      (i_task_id),
        .i_period       (i_period),
        .i_priority_req (i_priority_req),
        .o_strobe       (o_strobe),
        .o_fired_valid  (o_fired_valid),
        .o_fired_task   (o_fired_task),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Push one expected result
    function automatic void push_result(logic valid, logic [7:0] task_id, t_status st,
                                        logic last);
        dispatch_result_t r;
        r.fired_valid = valid;
        r.fired_task  = task_id;
        r.status      = st;
        r.last        = last;
        pending_results_q.push_back(r);
    endfunction

    // Update the table copy for one accepted transaction and queue its results
    function automatic void predict_dispatch(logic [1:0] op, logic [7:0] id,
                                             logic [15:0] per, logic [7:0] pri);
        logic [7:0] fired [MAX_RESULTS];
        int         n_fired;
        int         pos;
        int         wr;
        bit         found;
        n_fired = 0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < sched_count; i++) begin
                    if (sched_countdown[i] == 16'd0) begin
                        sched_countdown[i] = sched_period[i];
                        if (n_fired < MAX_RESULTS) begin
                            fired[n_fired] = sched_id[i];
                            n_fired++;
                        end
                    end else begin
                        sched_countdown[i] = sched_countdown[i] - 16'd1;
                    end
                end
                if (n_fired == 0) begin
                    push_result(1'b0, 8'd0, ST_DONE, 1'b1);
                end else begin
                    for (int k = 0; k < n_fired; k++)
                        push_result(1'b1, fired[k], ST_DONE, k == n_fired - 1);
                end
            end
            OP_ADD: begin
                if (sched_count >= TABLE_DEPTH) begin
                    push_result(1'b0, 8'd0, ST_FULL, 1'b1);
                end else begin
                    // insert behind every entry of equal or lower priority value
                    pos = 0;
                    while (pos < sched_count && sched_priority[pos] <= pri)
                        pos++;
                    for (int i = sched_count; i > pos; i--) begin
                        sched_id[i]        = sched_id[i-1];
                        sched_period[i]    = sched_period[i-1];
                        sched_countdown[i] = sched_countdown[i-1];
                        sched_priority[i]  = sched_priority[i-1];
                    end
                    sched_id[pos]        = id;
                    sched_period[pos]    = per;
                    sched_countdown[pos] = per;
                    sched_priority[pos]  = pri;
                    sched_count++;
                    push_result(1'b0, 8'd0, ST_DONE, 1'b1);
                end
            end
            OP_REMOVE: begin
                // drop every matching row and compact the rest in order
                wr    = 0;
                found = 1'b0;
                for (int rd = 0; rd < sched_count; rd++) begin
                    if (sched_id[rd] == id) begin
                        found = 1'b1;
                    end else begin
                        sched_id[wr]        = sched_id[rd];
                        sched_period[wr]    = sched_period[rd];
                        sched_countdown[wr] = sched_countdown[rd];
                        sched_priority[wr]  = sched_priority[rd];
                        wr++;
                    end
                end
                sched_count = wr;
                push_result(1'b0, 8'd0, found ? ST_DONE : ST_NOT_FOUND, 1'b1);
            end
            default: begin
                push_result(1'b0, 8'd0, ST_DONE, 1'b1);
            end
        endcase
    endfunction

    // Send one transaction, wait for it to be taken, then maybe hold off
    task automatic send_item(logic [1:0] op, logic [7:0] id, logic [15:0] per,
                             logic [7:0] pri);
        i_op           = op;
        i_task_id      = id;
        i_period       = per;
        i_priority_req = pri;
        start          = 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predict_dispatch(op, id, per, pri);
        @(negedge i_clk);
        if ($urandom_range(1, 100) <= sender_idle_pct) begin
            start          = 1'b0;
            i_op           = 2'($urandom);
            i_task_id      = 8'($urandom);
            i_period       = 16'($urandom);
            i_priority_req = 8'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    // Empty table: empty tick, remove of an absent id, unused opcode
    task automatic test_empty_table();
        send_item(OP_TICK, 8'd0, 16'd0, 8'd0);
        send_item(OP_REMOVE, 8'd7, 16'd0, 8'd0);
        send_item(OP_UNUSED, 8'hFF, 16'hFFFF, 8'hFF);
    endtask

    // Fill the table with priority ties, field extremes and a duplicate id
    task automatic test_ordered_add();
        send_item(OP_ADD, 8'h10, 16'd0, 8'd5);
        send_item(OP_ADD, 8'h00, 16'd0, 8'd255);
        send_item(OP_ADD, 8'hFF, 16'hFFFF, 8'd0);
        send_item(OP_ADD, 8'h21, 16'd1, 8'd5);
        send_item(OP_ADD, 8'h10, 16'd0, 8'd5);
        send_item(OP_ADD, 8'h33, 16'd0, 8'd2);
        send_item(OP_ADD, 8'h44, 16'd2, 8'd128);
        send_item(OP_ADD, 8'h55, 16'd0, 8'd5);
        // table is full now
        send_item(OP_ADD, 8'h66, 16'd0, 8'd1);
    endtask

    // Several ticks with many tasks firing at once
    task automatic test_tick_firing();
        repeat (3) send_item(OP_TICK, 8'd0, 16'd0, 8'd0);
    endtask

    // Remove duplicates, remove again, tick, remove another id, then re-add at the front
    task automatic test_remove();
        send_item(OP_REMOVE, 8'h10, 16'd0, 8'd0);
        send_item(OP_REMOVE, 8'h10, 16'd0, 8'd0);
        send_item(OP_TICK, 8'd0, 16'd0, 8'd0);
        send_item(OP_REMOVE, 8'hFF, 16'd0, 8'd0);
        send_item(OP_ADD, 8'h77, 16'd0, 8'd0);
    endtask

    // Random mix weighted toward small ids, close priorities and short periods
    task automatic test_random_traffic(int idle_pct, int n_items);
        logic [1:0]  op;
        logic [7:0]  id;
        logic [15:0] per;
        logic [7:0]  pri;
        int          r;
        int          add_w;
        sender_idle_pct = idle_pct;
        repeat (n_items) begin
            id  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 11)) : 8'($urandom);
            pri = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            r   = $urandom_range(0, 9);
            if (r < 6)
                per = 16'($urandom_range(0, 3));
            else if (r < 8)
                per = 16'($urandom_range(4, 20));
            else if (r == 8)
                per = 16'($urandom);
            else
                per = 16'hFFFF;
            add_w = (sched_count >= TABLE_DEPTH - 1) ? 20 : 28;
            r     = $urandom_range(0, 99);
            if (r < 4) begin
                op = OP_UNUSED;
            end else if (r < 50) begin
                op = OP_TICK;
            end else if (r < 50 + add_w) begin
                op = OP_ADD;
            end else begin
                op = OP_REMOVE;
                // mostly target a task that is present
                if (sched_count > 0 && $urandom_range(0, 9) < 7)
                    id = sched_id[$urandom_range(0, sched_count - 1)];
            end
            send_item(op, id, per, pri);
        end
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        dispatch_result_t exp_res;
        if (i_rst_n) begin
            if ($isunknown(o_strobe)) begin
                $error("o_strobe: expected 0 or 1, got %b", o_strobe);
                err_count++;
            end else if (o_strobe) begin
                if (pending_results_q.size() == 0) begin
                    $error("result strobe with no transaction pending");
                    err_count++;
                end else begin
                    exp_res = pending_results_q.pop_front();
                    if (o_fired_valid !== exp_res.fired_valid) begin
                        $error("fired_valid: expected %0d, got %0d",
                               exp_res.fired_valid, o_fired_valid);
                        err_count++;
                    end
                    if (o_fired_task !== exp_res.fired_task) begin
                        $error("fired_task: expected 0x%02h, got 0x%02h",
                               exp_res.fired_task, o_fired_task);
                        err_count++;
                    end
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d", exp_res.status, o_status);
                        err_count++;
                    end
                    if (o_last !== exp_res.last) begin
                        $error("last: expected %0d, got %0d", exp_res.last, o_last);
                        err_count++;
                    end
                end
            end
        end
    end

    // Abort when neither side moves a transaction for too long
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        err_count       = 0;
        quiet_cycles    = 0;
        sched_count     = 0;
        sender_idle_pct = 29;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_op            = 2'd0;
        i_task_id       = 8'd0;
        i_period        = 16'd0;
        i_priority_req  = 8'd0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_ordered_add();
        test_tick_firing();
        test_remove();
        test_random_traffic(29, 120);
        test_random_traffic(80, 110);
        test_random_traffic(0, 110);

        // Drop start and drain the remaining results
        start = 1'b0;
        while (pending_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/ptd_pkg.sv
rtl/ptd_table.sv
rtl/periodic_task_dispatcher_unit.sv
sim/tb.sv
